### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Each use expects clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// A signal is low in the cycle after reset is asserted.
`define ASSERT_LOW_AFTER_RESET(label, sig) \
  label: assert property (@(posedge clk) rst |=> !(sig)) \
    else $error("signal not cleared by reset");

`endif

### sv/upd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upd_pkg
// Types, character constants and the hex digit helper for the URL
// percent decoder.
// ---------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;

  // Escape tracking, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE        = 3'b001,
    PH_WAIT_FIRST  = 3'b010,
    PH_WAIT_SECOND = 3'b100
  } phase_t;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  // Decodes one ASCII hex digit; non-digits give is_hex = 0 and value = 0.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      h.is_hex = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      h.is_hex = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      h.is_hex = 1'b1;
    end
    h.value = d[3:0];
    return h;
  endfunction

endpackage

### sv/upd_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upd_in_if
// Input channel: one encoded character per beat.
// ---------------------------------------------------------------------------
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### sv/upd_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upd_out_if
// Output channel: one result per beat.
// ---------------------------------------------------------------------------
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_valid, output out_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_valid, input out_byte, input out_last,
                  output ready);
endinterface

### sv/upd_in_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upd_in_stage
// Input register. Takes a beat whenever it is empty or being drained.
// ---------------------------------------------------------------------------
module upd_in_stage (
  input  logic              clk,
  input  logic              rst,
  upd_in_if.sink            in_ch,
  input  logic              take,
  output logic              beat_valid,
  output upd_pkg::in_beat_t beat
);
  import upd_pkg::*;

  logic accept;

  // Ready while the register is free or its content moves on this cycle.
  assign in_ch.ready = !beat_valid || take;
  assign accept      = in_ch.valid && in_ch.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (accept) begin
      beat_valid <= 1'b1;
    end else if (take) begin
      beat_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      beat.in_byte <= in_ch.in_byte;
      beat.in_last <= in_ch.in_last;
    end
  end

endmodule

### sv/upd_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upd_decode
// Percent and plus decoding with the escape state registers. The state
// advances only on cycles where the held beat moves to the result register.
// ---------------------------------------------------------------------------
module upd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  upd_pkg::in_beat_t beat,
  output upd_pkg::result_t  result
);
  import upd_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] first_nibble, first_nibble_next;
  logic       first_is_hex, first_is_hex_next;
  hex_t       hex;

  assign hex = hex_decode(beat.in_byte);

  // Next state and the result for the current beat.
  always_comb begin
    phase_next        = phase;
    first_nibble_next = first_nibble;
    first_is_hex_next = first_is_hex;
    result.out_valid  = 1'b0;
    result.out_byte   = '0;
    result.out_last   = beat.in_last;

    unique case (phase)
      PH_WAIT_FIRST: begin
        first_is_hex_next = hex.is_hex;
        first_nibble_next = hex.value;
        phase_next        = PH_WAIT_SECOND;
      end
      PH_WAIT_SECOND: begin
        result.out_valid = 1'b1;
        if (first_is_hex) begin
          result.out_byte = hex.is_hex ? {first_nibble, hex.value}
                                       : {4'h0, first_nibble};
        end
        phase_next = PH_IDLE;
      end
      default: begin
        if (beat.in_byte == CharPercent) begin
          phase_next = PH_WAIT_FIRST;
        end else if (beat.in_byte == CharPlus) begin
          result.out_valid = 1'b1;
          result.out_byte  = CharSpace;
          phase_next       = PH_IDLE;
        end else begin
          result.out_valid = 1'b1;
          result.out_byte  = beat.in_byte;
          phase_next       = PH_IDLE;
        end
      end
    endcase

    // The end of a string drops any partial escape.
    if (beat.in_last) begin
      phase_next        = PH_IDLE;
      first_nibble_next = '0;
      first_is_hex_next = 1'b0;
    end
  end

  // Escape state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      first_nibble <= '0;
      first_is_hex <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      first_nibble <= first_nibble_next;
      first_is_hex <= first_is_hex_next;
    end
  end

endmodule

### sv/upd_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upd_out_stage
// Result register driving the output channel.
// ---------------------------------------------------------------------------
module upd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  upd_pkg::result_t load_data,
  output logic             load_ready,
  upd_out_if.source        out_ch
);
  import upd_pkg::*;

  result_t held;
  logic    load;

  // Room when empty or when the held beat leaves this cycle.
  assign load_ready = !out_ch.valid || out_ch.ready;
  assign load       = load_valid && load_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

  assign out_ch.out_valid = held.out_valid;
  assign out_ch.out_byte  = held.out_byte;
  assign out_ch.out_last  = held.out_last;

endmodule

### sv/url_percent_decoder_unit.sv
// Path: an accepted beat is held in the input register, decoded combinationally, and then
// loaded into the result register when it has room; the result is offered from there.
// Throughput: one beat per cycle while the output channel is ready, set by the single
// decode stage between the input register and the result register.
// Reset: synchronous and active high; clears both valid flags and the escape state.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// url_percent_decoder_unit
// URL percent decoder: '+' becomes a space, a complete '%' escape of two characters
// becomes one byte, all other characters pass through. One result per beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module url_percent_decoder_unit (
  input  logic      clk,
  input  logic      rst,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);
  import upd_pkg::*;

  logic     beat_valid;
  in_beat_t beat;
  result_t  result;
  logic     load_ready;
  logic     advance;

  // The held beat is decoded when the result register can take it.
  assign advance = beat_valid && load_ready;

  upd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .take       (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  upd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .beat    (beat),
    .result  (result)
  );

  upd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load_valid (beat_valid),
    .load_data  (result),
    .load_ready (load_ready),
    .out_ch     (out_ch)
  );

  // Checks.
  `ASSERT_IMPLIES(a_no_byte_is_zero, out_ch.valid && !out_ch.out_valid, out_ch.out_byte == 8'h00)
  `ASSERT_IMPLIES(a_ready_when_out_empty, !out_ch.valid, in_ch.ready)
  `ASSERT_LOW_AFTER_RESET(a_out_cleared, out_ch.valid)

endmodule
